// ----- hdl/sias_pkg.sv -----
// ----------------------------------------------------------------------------
// sias_pkg
// Types, codes and fixed widths shared by the shift/insert array store.
// ----------------------------------------------------------------------------
package sias_pkg;

  localparam int OP_BITS     = 3;
  localparam int INDEX_BITS  = 5;
  localparam int VALUE_BITS  = 32;
  localparam int AMOUNT_BITS = 5;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  // Wide enough for a count of up to 256 elements and for position sums
  localparam int CNT_BITS   = 9;
  localparam int POS_BITS   = 10;
  localparam int SHIFT_SPAN = 1 << AMOUNT_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_APPEND = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CK_HOLD,
    CK_WRITE,
    CK_APPEND,
    CK_INSERT,
    CK_REMOVE,
    CK_CLEAR
  } cell_kind_t;

  typedef struct packed {
    logic [OP_BITS-1:0]            op;
    logic [INDEX_BITS-1:0]         index;
    logic signed [VALUE_BITS-1:0]  value;
    logic [AMOUNT_BITS-1:0]        amount;
  } cmd_word_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0]  read_value;
    logic [COUNT_BITS-1:0]         count_after;
    logic [STATUS_BITS-1:0]        status;
  } rsp_word_t;

  typedef struct packed {
    cell_kind_t             kind;
    logic [CNT_BITS-1:0]    idx;
    logic [CNT_BITS-1:0]    cnt;
    logic [AMOUNT_BITS-1:0] amt;
  } cell_cmd_t;

  typedef struct packed {
    status_t             status;
    logic [CNT_BITS-1:0] count_next;
    logic                read_hit;
  } ctrl_info_t;

endpackage

// ----- hdl/sias_stream_if.sv -----
// ----------------------------------------------------------------------------
// sias_stream_if
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface sias_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/shift_insert_array_store_core.sv -----
// ----------------------------------------------------------------------------
// shift_insert_array_store_core
// Fixed-capacity array of signed words with read, write, append, insert,
// remove and clear, built as a row of cells that shift in one step.
//
//   channel  direction  word        fields
//   cmd      in         cmd_word_t  op, index, value, amount
//   result   out        rsp_word_t  read_value, count_after, status
//
// One word per cycle: every cell picks its new value from a neighbour at the
// shift distance, so insert and remove finish in the cycle they are accepted.
// The result sits in an output register the cycle after; a new word is taken
// while that register is empty or being drained. Reset zeroes every cell and
// the count; a stalled result holds the register and blocks cmd.
// ----------------------------------------------------------------------------
module shift_insert_array_store_core
  import sias_pkg::*;
#(
  parameter int CAPACITY  = 16,
  parameter int WORD_BITS = 32
) (
  input  logic  clk,
  input  logic  rst,
  sias_stream_if.sink   cmd,
  sias_stream_if.source result
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                 accept;
  logic [CNT_W-1:0]     count;
  cell_cmd_t            cell_cmd;
  ctrl_info_t           info;
  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] cell_q [CAPACITY];
  logic [WORD_BITS-1:0] rd_word;
  logic [VALUE_BITS-1:0] rd_value;
  logic                 out_valid;
  rsp_word_t            out_word;

  assign cmd.ready = !out_valid || result.ready;
  assign accept    = cmd.valid && cmd.ready;

  sias_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .accept   (accept),
    .word     (cmd.data),
    .count    (CNT_BITS'(count)),
    .cell_cmd (cell_cmd),
    .info     (info)
  );

  generate
    if (WORD_BITS < VALUE_BITS) begin : g_narrow
      assign wdata    = cmd.data.value[WORD_BITS-1:0];
      assign rd_value = {{(VALUE_BITS-WORD_BITS){rd_word[WORD_BITS-1]}}, rd_word};
    end else if (WORD_BITS > VALUE_BITS) begin : g_wide
      assign wdata    = {{(WORD_BITS-VALUE_BITS){cmd.data.value[VALUE_BITS-1]}},
                         cmd.data.value};
      assign rd_value = rd_word[VALUE_BITS-1:0];
    end else begin : g_equal
      assign wdata    = cmd.data.value;
      assign rd_value = rd_word;
    end
  endgenerate

  for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
    logic [WORD_BITS-1:0] lower [SHIFT_SPAN];
    logic [WORD_BITS-1:0] upper [SHIFT_SPAN];

    for (genvar k = 0; k < SHIFT_SPAN; k++) begin : g_tap
      if (p >= k) begin : g_lo
        assign lower[k] = cell_q[p-k];
      end else begin : g_lo_edge
        assign lower[k] = '0;
      end
      if (p + k < CAPACITY) begin : g_up
        assign upper[k] = cell_q[p+k];
      end else begin : g_up_edge
        assign upper[k] = '0;
      end
    end

    sias_cell #(
      .WORD_BITS (WORD_BITS),
      .POS       (p)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cell_cmd),
      .wdata (wdata),
      .lower (lower),
      .upper (upper),
      .q     (cell_q[p])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_BITS'(i) == CNT_BITS'(cmd.data.index)) rd_word = cell_q[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= CNT_W'(info.count_next);
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word.read_value  <= info.read_hit ? rd_value : '0;
      out_word.count_after <= info.count_next[COUNT_BITS-1:0];
      out_word.status      <= info.status;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_word;

endmodule

// ----- hdl/sias_cell.sv -----
// ----------------------------------------------------------------------------
// sias_cell
// One element of the array: picks its next word from the write data, itself,
// a neighbour at the shift distance, or zero on clear.
// ----------------------------------------------------------------------------
module sias_cell
  import sias_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int POS       = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_cmd_t            cmd,
  input  logic [WORD_BITS-1:0] wdata,
  input  logic [WORD_BITS-1:0] lower [SHIFT_SPAN],
  input  logic [WORD_BITS-1:0] upper [SHIFT_SPAN],
  output logic [WORD_BITS-1:0] q
);

  localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(POS);

  logic [WORD_BITS-1:0] q_next;
  logic [POS_BITS-1:0]  idx;
  logic [POS_BITS-1:0]  cnt;
  logic [POS_BITS-1:0]  amt;

  assign idx = POS_BITS'(cmd.idx);
  assign cnt = POS_BITS'(cmd.cnt);
  assign amt = POS_BITS'(cmd.amt);

  always_comb begin
    q_next = q;
    unique case (cmd.kind)
      CK_WRITE: begin
        if (MY_POS == idx) q_next = wdata;
      end
      CK_APPEND: begin
        if (MY_POS == cnt) q_next = wdata;
      end
      CK_INSERT: begin
        if (MY_POS >= idx && MY_POS < idx + amt) begin
          q_next = wdata;
        end else if (MY_POS >= idx + amt && MY_POS < cnt + amt) begin
          q_next = lower[cmd.amt];
        end
      end
      CK_REMOVE: begin
        if (MY_POS >= idx && MY_POS + amt < cnt) q_next = upper[cmd.amt];
      end
      CK_CLEAR: q_next = '0;
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      q <= q_next;
    end
  end

endmodule

// ----- hdl/sias_ctrl.sv -----
// ----------------------------------------------------------------------------
// sias_ctrl
// Operation decode: range checks, status, new count and the command that is
// broadcast to every cell.
// ----------------------------------------------------------------------------
module sias_ctrl
  import sias_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                accept,
  input  cmd_word_t           word,
  input  logic [CNT_BITS-1:0] count,
  output cell_cmd_t           cell_cmd,
  output ctrl_info_t          info
);

  localparam logic [CNT_BITS-1:0] CAP = CNT_BITS'(CAPACITY);

  logic [CNT_BITS-1:0] idx;
  logic [CNT_BITS-1:0] amt;
  logic [CNT_BITS-1:0] tail;
  cell_kind_t          kind;

  assign idx  = CNT_BITS'(word.index);
  assign amt  = CNT_BITS'(word.amount);
  assign tail = count - idx;

  always_comb begin
    kind            = CK_HOLD;
    info.status     = ST_DONE;
    info.count_next = count;
    info.read_hit   = 1'b0;
    unique case (word.op)
      OP_READ: begin
        if (idx < count) info.read_hit = 1'b1;
        else info.status = ST_BAD_INDEX;
      end
      OP_WRITE: begin
        if (idx < CAP) begin
          kind = CK_WRITE;
          if (idx >= count) info.count_next = idx + 1'b1;
        end else begin
          info.status = ST_BAD_INDEX;
        end
      end
      OP_APPEND: begin
        if (count < CAP) begin
          kind            = CK_APPEND;
          info.count_next = count + 1'b1;
        end else begin
          info.status = ST_FULL;
        end
      end
      OP_INSERT: begin
        if (idx > count) begin
          info.status = ST_BAD_INDEX;
        end else if (count + amt > CAP) begin
          info.status = ST_FULL;
        end else if (amt != '0) begin
          kind            = CK_INSERT;
          info.count_next = count + amt;
        end
      end
      OP_REMOVE: begin
        if (idx >= count) begin
          info.status = ST_BAD_INDEX;
        end else begin
          kind            = CK_REMOVE;
          info.count_next = (amt > tail) ? idx : count - amt;
        end
      end
      OP_CLEAR: begin
        kind            = CK_CLEAR;
        info.count_next = '0;
      end
      default: kind = CK_HOLD;
    endcase
  end

  assign cell_cmd.kind = accept ? kind : CK_HOLD;
  assign cell_cmd.idx  = idx;
  assign cell_cmd.cnt  = count;
  assign cell_cmd.amt  = word.amount;

endmodule
